// ----- rtl/pcs_pkg.sv -----
// Shared types and constants for the PNG chunk stripper.
// Used by pcs_parser, pcs_out_buf and png_chunk_stripper_core; no dependencies.
`default_nettype none

package pcs_pkg;

    // Configuration register indexes
    localparam logic CFG_FILE_LENGTH = 1'b0;
    localparam logic CFG_DROP_TYPE   = 1'b1;

    // Register reset values
    localparam logic [31:0] FILE_LENGTH_RST = 32'h0000_0000;
    localparam logic [31:0] DROP_TYPE_RST   = 32'h6349_4350;  // "cICP"

    // Chunk types and sizes
    localparam logic [31:0] IEND_TYPE = 32'h4945_4E44;        // "IEND"
    localparam logic [32:0] MIN_CHUNK = 33'd12;               // length + type + CRC
    localparam logic [33:0] HDR_TAIL  = 34'd5;                // chunk end minus last header byte
    localparam logic [32:0] CRC_BYTES = 33'd4;

    // Status codes
    localparam logic [1:0] ST_STRIPPED = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_BAD_SIG  = 2'd2;

    // Parser phases
    typedef enum logic [1:0] {
        PH_SIG,
        PH_HEADER,
        PH_BODY,
        PH_STOP
    } phase_t;

    // Burst handed from the parser to the output buffer
    typedef struct packed {
        logic            load;
        logic [7:0][7:0] data;        // data words, slot 0 first
        logic [3:0]      ndata;       // 0, 1 or 8 data words
        logic            has_status;
        logic [1:0]      status_code;
    } burst_t;

    // PNG file signature byte at a given position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0: val = 8'h89;
            3'd1: val = 8'h50;
            3'd2: val = 8'h4E;
            3'd3: val = 8'h47;
            3'd4: val = 8'h0D;
            3'd5: val = 8'h0A;
            3'd6: val = 8'h1A;
            3'd7: val = 8'h0A;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/png_chunk_stripper_core.sv -----
// PNG chunk stripper top level: one file word in per cycle while s_ready is high, filtered words out.
// The first result is registered and appears in the cycle after the input word is accepted.
// Throughput: one word per cycle if m_ready; a passed chunk header drains as 8 words
// (9 with a status word), during which input waits for the result register.
// Reset: synchronous active-low aresetn clears parse state and sets
// file_length to 0 and drop_type to "cICP". Depends on pcs_pkg, pcs_parser, pcs_out_buf.
`default_nettype none

module png_chunk_stripper_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_final_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_is_status,
    output logic [1:0]       m_status_code,
    output logic             m_run_end
);
    import pcs_pkg::*;

    logic [31:0] file_length_reg;
    logic [31:0] drop_type_reg;
    logic        accept;
    burst_t      burst;

    assign accept = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= FILE_LENGTH_RST;
            drop_type_reg   <= DROP_TYPE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FILE_LENGTH: file_length_reg <= cfg_data;
                CFG_DROP_TYPE:   drop_type_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    pcs_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_byte     (s_in_byte),
        .final_byte  (s_final_byte),
        .file_length (file_length_reg),
        .drop_type   (drop_type_reg),
        .burst       (burst)
    );

    pcs_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .burst         (burst),
        .can_load      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_status   (m_is_status),
        .m_status_code (m_status_code),
        .m_run_end     (m_run_end)
    );

endmodule

`default_nettype wire

// ----- rtl/pcs_parser.sv -----
// Chunk parser: signature check, header gathering, body pass/drop per input word.
// Depends on pcs_pkg; produces a burst_t for pcs_out_buf.
`default_nettype none

module pcs_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [7:0]     in_byte,
    input  wire logic           final_byte,
    input  wire logic [31:0]    file_length,
    input  wire logic [31:0]    drop_type,
    output pcs_pkg::burst_t     burst
);
    import pcs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    logic [32:0] left_reg, left_next;
    logic        drop_reg, drop_next;
    logic        stop_reg, stop_next;
    logic        removed_reg, removed_next;
    logic        sig_ok_reg, sig_ok_next;
    logic [7:0]  hdr_reg [8];
    logic        hdr_we;
    logic [31:0] hdr_length;
    logic [31:0] chunk_type;
    logic [32:0] left_dec;

    assign hdr_length = {hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3]};
    assign chunk_type = {hdr_reg[4], hdr_reg[5], hdr_reg[6], in_byte};
    assign left_dec   = left_reg - {32'd0, (left_reg != 33'd0)};

    // Next state and burst for the word at the input
    always_comb begin
        phase_next   = phase_reg;
        hcnt_next    = hcnt_reg;
        left_next    = left_reg;
        drop_next    = drop_reg;
        stop_next    = stop_reg;
        removed_next = removed_reg;
        sig_ok_next  = sig_ok_reg;
        hdr_we       = 1'b0;
        burst        = '0;
        burst.load   = accept;

        case (phase_reg)
            PH_SIG: begin
                if (in_byte != sig_byte(pos_reg[2:0])) begin
                    sig_ok_next = 1'b0;
                end
                burst.ndata   = 4'd1;
                burst.data[0] = in_byte;
                if (pos_reg >= 32'd7) begin
                    phase_next = sig_ok_next ? PH_HEADER : PH_STOP;
                    hcnt_next  = 3'd0;
                end
            end
            PH_HEADER: begin
                if (hcnt_reg == 3'd0 &&
                    ({1'b0, pos_reg} + MIN_CHUNK) > {1'b0, file_length}) begin
                    phase_next = PH_STOP;
                end else begin
                    hdr_we = 1'b1;
                    if (hcnt_reg == 3'd7) begin
                        hcnt_next = 3'd0;
                        if (({2'b0, pos_reg} + HDR_TAIL + {2'b0, hdr_length}) >
                            {2'b0, file_length}) begin
                            phase_next = PH_STOP;
                        end else begin
                            drop_next = (chunk_type == drop_type);
                            if (chunk_type == drop_type) begin
                                removed_next = 1'b1;
                            end else begin
                                burst.ndata   = 4'd8;
                                burst.data[0] = hdr_reg[0];
                                burst.data[1] = hdr_reg[1];
                                burst.data[2] = hdr_reg[2];
                                burst.data[3] = hdr_reg[3];
                                burst.data[4] = hdr_reg[4];
                                burst.data[5] = hdr_reg[5];
                                burst.data[6] = hdr_reg[6];
                                burst.data[7] = in_byte;
                            end
                            stop_next  = (chunk_type == IEND_TYPE);
                            left_next  = {1'b0, hdr_length} + CRC_BYTES;
                            phase_next = PH_BODY;
                        end
                    end else begin
                        hcnt_next = hcnt_reg + 3'd1;
                    end
                end
            end
            PH_BODY: begin
                if (!drop_reg) begin
                    burst.ndata   = 4'd1;
                    burst.data[0] = in_byte;
                end
                left_next = left_dec;
                if (left_dec == 33'd0) begin
                    phase_next = stop_reg ? PH_STOP : PH_HEADER;
                    hcnt_next  = 3'd0;
                end
            end
            default: begin
            end
        endcase

        // Saturating received-word count
        pos_next = (pos_reg == 32'hFFFF_FFFF) ? pos_reg : pos_reg + 32'd1;

        // Close the file: report status and return to the start
        if (final_byte) begin
            burst.has_status = 1'b1;
            if (!sig_ok_next || phase_next == PH_SIG) begin
                burst.status_code = ST_BAD_SIG;
            end else begin
                burst.status_code = removed_next ? ST_STRIPPED : ST_NO_MATCH;
            end
            phase_next   = PH_SIG;
            pos_next     = 32'd0;
            hcnt_next    = 3'd0;
            left_next    = 33'd0;
            drop_next    = 1'b0;
            stop_next    = 1'b0;
            removed_next = 1'b0;
            sig_ok_next  = 1'b1;
        end
    end

    // Advance parse state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            pos_reg     <= 32'd0;
            hcnt_reg    <= 3'd0;
            left_reg    <= 33'd0;
            drop_reg    <= 1'b0;
            stop_reg    <= 1'b0;
            removed_reg <= 1'b0;
            sig_ok_reg  <= 1'b1;
        end else if (accept) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            hcnt_reg    <= hcnt_next;
            left_reg    <= left_next;
            drop_reg    <= drop_next;
            stop_reg    <= stop_next;
            removed_reg <= removed_next;
            sig_ok_reg  <= sig_ok_next;
        end
    end

    // Capture header words
    always_ff @(posedge aclk) begin
        if (accept && hdr_we) begin
            hdr_reg[hcnt_reg] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pcs_out_buf.sv -----
// Result register: holds one burst and drains it one word per cycle while m_ready is high.
// Depends on pcs_pkg (burst_t).
`default_nettype none

module pcs_out_buf (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire pcs_pkg::burst_t burst,
    output logic                 can_load,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_is_status,
    output logic [1:0]           m_status_code,
    output logic                 m_run_end
);
    import pcs_pkg::*;

    logic [7:0] data_reg [8];
    logic [3:0] ndata_reg;
    logic [3:0] total_reg;
    logic [3:0] idx_reg;
    logic [1:0] code_reg;
    logic       last;
    logic       take;

    assign m_valid  = (idx_reg != total_reg);
    assign last     = (idx_reg == total_reg - 4'd1);
    assign take     = m_valid && m_ready;
    assign can_load = !m_valid || (take && last);

    // Select the word at the read index
    always_comb begin
        m_is_status   = (idx_reg >= ndata_reg);
        m_out_byte    = m_is_status ? 8'd0 : data_reg[idx_reg[2:0]];
        m_status_code = m_is_status ? code_reg : ST_STRIPPED;
        m_run_end     = last;
    end

    // Load a new burst or advance through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= 4'd0;
            idx_reg   <= 4'd0;
            ndata_reg <= 4'd0;
        end else if (burst.load) begin
            total_reg <= burst.ndata + {3'd0, burst.has_status};
            idx_reg   <= 4'd0;
            ndata_reg <= burst.ndata;
        end else if (take) begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    // Hold burst payload
    always_ff @(posedge aclk) begin
        if (burst.load) begin
            for (int i = 0; i < 8; i++) begin
                data_reg[i] <= burst.data[i];
            end
            code_reg <= burst.status_code;
        end
    end

endmodule

`default_nettype wire
